// ----- design/pca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types, constants and helper functions for the palette color adjust
// block.
// ----------------------------------------------------------------------------
package pca_pkg;

   localparam int INDEX_W   = 15;
   localparam int WIDE_W    = 32;
   localparam int NARROW_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int LEVEL_W   = 6;
   localparam int CHANNELS  = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 6'd63;

   // reciprocals for the constant divisions
   localparam logic [13:0] RECIP7   = 14'd9363;  // x/7 as (x*9363)>>16, x < 512
   localparam logic [12:0] RECIP100 = 13'd5243;  // x/100 as (x*5243)>>19, x < 16384

   // luma weights over 65536
   localparam logic [15:0] W_RED   = 16'd19660;
   localparam logic [15:0] W_GREEN = 16'd38666;
   localparam logic [15:0] W_BLUE  = 16'd7208;

   localparam logic [11:0] HIGHLIGHT_OFS = 12'h777;

   localparam logic [WIDE_W-1:0]   ALPHA_OPAQUE = 32'hFF00_0000;
   localparam logic [WIDE_W-1:0]   PINK_WIDE    = 32'h00FF_00FF;
   localparam logic [NARROW_W-1:0] PINK_RGB565  = 16'hF81F;
   localparam logic [NARROW_W-1:0] PINK_RGB555  = 16'h7C1F;
   localparam logic [23:0]         INVERT_WIDE  = 24'hFF_FFFF;
   localparam logic [NARROW_W-1:0] INVERT_NARROW = 16'hFFFF;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RED_GAIN     = 3'd0,
      REG_GREEN_GAIN   = 3'd1,
      REG_BLUE_GAIN    = 3'd2,
      REG_BRIGHTNESS   = 3'd3,
      REG_CONTRAST     = 3'd4,
      REG_EFFECT_FLAGS = 3'd5
   } reg_index_type;

   // effect flag bits
   localparam int FLAG_GREY   = 0;
   localparam int FLAG_INVERT = 1;
   localparam int FLAG_PINK   = 2;
   localparam int FLAG_RGB555 = 3;

   // palette pages
   typedef enum logic [1:0] {
      PAGE_BASE      = 2'd0,
      PAGE_SHADOW    = 2'd1,
      PAGE_HIGHLIGHT = 2'd2,
      PAGE_NORMAL    = 2'd3
   } page_type;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic signed [6:0]  offset_type;

   // brightness offset (b-100)*32/100, truncated toward zero
   function automatic offset_type brightness_offset(input logic [7:0] bright);
      logic signed [8:0] d;
      logic        [7:0] mag;
      logic       [12:0] scaled;
      logic       [24:0] prod;
      logic        [5:0] q;
      d      = $signed({1'b0, bright}) - 9'sd100;
      mag    = d[8] ? 8'(-d) : d[7:0];
      scaled = {mag, 5'b00000};
      prod   = 25'(scaled) * 25'(RECIP100);
      q      = prod[24:19];
      return d[8] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   function automatic logic [NARROW_W-1:0] pack_narrow(input level_type r,
                                                       input level_type g,
                                                       input level_type b,
                                                       input logic      m555);
      if (m555) begin
         return {1'b0, r[5:1], g[5:1], b[5:1]};
      end
      return {r[5:1], g, b[5:1]};
   endfunction

endpackage

// ----- design/pca_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_req_if / pca_rsp_if
// Valid/ready channels carrying palette indexes in and colors out.
// ----------------------------------------------------------------------------
interface pca_req_if
   import pca_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] palette_index;

   modport source (output valid, output palette_index, input ready);
   modport sink   (input valid, input palette_index, output ready);
endinterface

interface pca_rsp_if
   import pca_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [WIDE_W-1:0]   color_wide;
   logic [NARROW_W-1:0] color_narrow;

   modport source (output valid, output color_wide, output color_narrow, input ready);
   modport sink   (input valid, input color_wide, input color_narrow, output ready);
endinterface

// ----- design/palette_color_adjust.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_color_adjust
// Six-stage pipeline turning a palette index into an ARGB and a 16-bit color.
// ----------------------------------------------------------------------------
// usage
//  - req_chan takes one palette index per item, rsp_chan returns one item
//    with color_wide (ARGB) and color_narrow (rgb565, or rgb555 by flag)
//  - every accepted item gives exactly one result item, in order
//  - six register stages, stage 0 to stage 5; an accepted item passes them in
//    order and shows on rsp_chan from the stage 5 output register
//  - throughput: one item per cycle while nothing stalls, set by the six stages each
//    taking a new item every cycle (gain, divide, contrast, divide, luma product, luma sum)
//  - csr port: csr_we with csr_index and csr_wdata writes one register per
//    edge; the user must make writes only while no item is in flight, the block does not enforce it
//  - the brightness register is kept as its precomputed offset
//  - reset (synchronous, active high) empties the pipeline and loads the
//    register defaults: gains 255, brightness 100, contrast 100, flags 0
//  - when the receiver stalls, each stage holds its item; a stage with a
//    bubble still takes a new item, so req_chan.ready only drops once the
//    stage chain in front of the stall is full
// ----------------------------------------------------------------------------
module palette_color_adjust
   import pca_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pca_req_if.sink               req_chan,
   pca_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int STAGES = 6;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [7:0] gain_ff [CHANNELS];
   offset_type offset_ff;
   logic [7:0] contrast_ff;
   logic [3:0] flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            gain_ff[c] <= 8'd255;
         end
         offset_ff   <= '0;
         contrast_ff <= 8'd100;
         flags_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RED_GAIN:     gain_ff[0]  <= csr_wdata;
            REG_GREEN_GAIN:   gain_ff[1]  <= csr_wdata;
            REG_BLUE_GAIN:    gain_ff[2]  <= csr_wdata;
            REG_BRIGHTNESS:   offset_ff   <= brightness_offset(csr_wdata);
            REG_CONTRAST:     contrast_ff <= csr_wdata;
            REG_EFFECT_FLAGS: flags_ff    <= csr_wdata[3:0];
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   wire m555 = flags_ff[FLAG_RGB555];

   // ---------------------------------------------------------------------
   // stage flow control: a stage loads when it is empty or its item moves on
   // ---------------------------------------------------------------------
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || rsp_chan.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_chan.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_chan.valid;
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // keep flag: index bit 14, exempts the entry from the pink background
   logic [STAGES-2:0] keep_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) keep_ff[0] <= req_chan.palette_index[14];
      for (int k = 1; k < STAGES - 1; k++) begin
         if (adv[k]) keep_ff[k] <= keep_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // stage 0: page remap and gain product level*gain
   // ---------------------------------------------------------------------
   logic [11:0] base;
   logic [13:0] x_in [CHANNELS];
   logic [13:0] x_ff [CHANNELS];

   always_comb begin
      unique case (page_type'(req_chan.palette_index[13:12]))
         PAGE_SHADOW:    base = {1'b0, req_chan.palette_index[11:1]};
         PAGE_HIGHLIGHT: base = {1'b0, req_chan.palette_index[11:1]} + HIGHLIGHT_OFS;
         default:        base = req_chan.palette_index[11:0];  // base and normal pages
      endcase
      for (int c = 0; c < CHANNELS; c++) begin
         x_in[c] = 14'({base[4*c +: 4], 2'b00}) * 14'(gain_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) x_ff <= x_in;
   end

   // ---------------------------------------------------------------------
   // stage 1: divide by 224 as (x>>5)/7, add brightness offset, clamp
   // ---------------------------------------------------------------------
   level_type v_in [CHANNELS];
   level_type v_ff [CHANNELS];

   always_comb begin
      logic [22:0]       div_prod;
      logic [6:0]        scaled;
      logic signed [8:0] sum;
      for (int c = 0; c < CHANNELS; c++) begin
         div_prod = 23'(x_ff[c][13:5]) * 23'(RECIP7);
         scaled   = div_prod[22:16];
         sum      = $signed({2'b00, scaled}) + 9'(offset_ff);
         if (sum < 0) begin
            v_in[c] = '0;
         end else if (sum > 9'sd63) begin
            v_in[c] = LEVEL_MAX;
         end else begin
            v_in[c] = sum[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) v_ff <= v_in;
   end

   // ---------------------------------------------------------------------
   // stage 2: contrast product
   // ---------------------------------------------------------------------
   logic [13:0] p_in [CHANNELS];
   logic [13:0] p_ff [CHANNELS];

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         p_in[c] = 14'(v_ff[c]) * 14'(contrast_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) p_ff <= p_in;
   end

   // ---------------------------------------------------------------------
   // stage 3: divide by 100 and clamp to the level range
   // ---------------------------------------------------------------------
   level_type lvl_in [CHANNELS];
   level_type lvl_ff [CHANNELS];

   always_comb begin
      logic [26:0] div_prod;
      logic [7:0]  quot;
      for (int c = 0; c < CHANNELS; c++) begin
         div_prod = 27'(p_ff[c]) * 27'(RECIP100);
         quot     = div_prod[26:19];
         lvl_in[c] = (quot > 8'(LEVEL_MAX)) ? LEVEL_MAX : quot[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) lvl_ff <= lvl_in;
   end

   // ---------------------------------------------------------------------
   // stage 4: luma weight products for the wide and the narrow color
   // ---------------------------------------------------------------------
   logic [15:0] weight [CHANNELS];
   level_type   nlvl   [CHANNELS];
   logic [23:0] pw_in  [CHANNELS];
   logic [21:0] pn_in  [CHANNELS];
   logic [23:0] pw_ff  [CHANNELS];
   logic [21:0] pn_ff  [CHANNELS];
   level_type   lvl4_ff [CHANNELS];

   always_comb begin
      weight[0] = W_RED;
      weight[1] = W_GREEN;
      weight[2] = W_BLUE;
      // narrow channels widened back to six bits after packing
      nlvl[0] = {lvl_ff[0][5:1], 1'b0};
      nlvl[1] = m555 ? {lvl_ff[1][5:1], 1'b0} : lvl_ff[1];
      nlvl[2] = {lvl_ff[2][5:1], 1'b0};
      for (int c = 0; c < CHANNELS; c++) begin
         pw_in[c] = 24'({lvl_ff[c], 2'b00}) * 24'(weight[c]);
         pn_in[c] = 22'(nlvl[c]) * 22'(weight[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         pw_ff   <= pw_in;
         pn_ff   <= pn_in;
         lvl4_ff <= lvl_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage 5: luma sums, pack, invert, pink background -> output register
   // ---------------------------------------------------------------------
   logic [WIDE_W-1:0]   wide_in,   wide_ff;
   logic [NARROW_W-1:0] narrow_in, narrow_ff;
   logic                pink_in,   pink_ff;

   always_comb begin
      logic [9:0] yw_sum;
      logic [7:0] yn_sum;
      logic [7:0] yw;
      level_type  yn;
      yw_sum = 10'(pw_ff[0][23:16]) + 10'(pw_ff[1][23:16]) + 10'(pw_ff[2][23:16]);
      yn_sum = 8'(pn_ff[0][21:16]) + 8'(pn_ff[1][21:16]) + 8'(pn_ff[2][21:16]);
      yw     = yw_sum[7:0];  // weights sum below one, stays under 256
      yn     = yn_sum[5:0];  // stays under 64 likewise

      if (flags_ff[FLAG_GREY]) begin
         wide_in   = ALPHA_OPAQUE | {8'h00, yw, yw, yw};
         narrow_in = pack_narrow(yn, yn, yn, m555);
      end else begin
         wide_in   = ALPHA_OPAQUE | {8'h00, lvl4_ff[0], 2'b00, lvl4_ff[1], 2'b00,
                                     lvl4_ff[2], 2'b00};
         narrow_in = pack_narrow(lvl4_ff[0], lvl4_ff[1], lvl4_ff[2], m555);
      end

      if (flags_ff[FLAG_INVERT]) begin
         wide_in   = wide_in ^ {8'h00, INVERT_WIDE};
         narrow_in = narrow_in ^ INVERT_NARROW;
      end

      pink_in = flags_ff[FLAG_PINK] && !keep_ff[STAGES-2];
      if (pink_in) begin
         wide_in   = PINK_WIDE;
         narrow_in = m555 ? PINK_RGB555 : PINK_RGB565;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         wide_ff   <= wide_in;
         narrow_ff <= narrow_in;
         pink_ff   <= pink_in;
      end
   end

   assign rsp_chan.valid        = vld_ff[STAGES-1];
   assign rsp_chan.color_wide   = wide_ff;
   assign rsp_chan.color_narrow = narrow_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[0])
      else $error("accepted item missing from first stage");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready && (&vld_ff)) |-> !req_chan.ready)
      else $error("input taken while pipeline full and stalled");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && !adv[5]) |=> (vld_ff[4] && $stable(pw_ff[1]) && $stable(lvl4_ff[0])))
      else $error("stalled stage lost or changed its item");

   a_pink_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && pink_ff) |-> (rsp_chan.color_wide == PINK_WIDE))
      else $error("pink item with wrong wide color");

endmodule
